/* sv/utfd_pkg.sv */
// ----------------------------------------------------------------------------
// utfd_pkg: UTF-8 stream decoder package
// Shared result type, lead byte classification and field widths.
// ----------------------------------------------------------------------------
package utfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned RemW  = 3;
  localparam int unsigned LeadW = 5;

  // Top two bits of a continuation byte
  localparam logic [1:0] ContTag = 2'b10;

  // Result counts produced by one byte
  localparam logic [1:0] NoResult  = 2'd0;
  localparam logic [1:0] OneResult = 2'd1;
  localparam logic [1:0] TwoResult = 2'd2;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           complete;
    logic           last_in_run;
  } result_t;

  typedef struct packed {
    logic             single;   // emitted as its own value
    logic [LeadW-1:0] payload;  // payload bits of a lead byte
    logic [RemW-1:0]  rem;      // continuation bytes that follow
  } lead_t;

  function automatic lead_t classify_lead(input logic [ByteW-1:0] b);
    lead_t l;
    l.single  = 1'b0;
    l.payload = '0;
    l.rem     = '0;
    case (b) inside
      [8'hC0:8'hDF]: begin
        l.payload = b[4:0];
        l.rem     = 3'd1;
      end
      [8'hE0:8'hEF]: begin
        l.payload = {1'b0, b[3:0]};
        l.rem     = 3'd2;
      end
      [8'hF0:8'hF7]: begin
        l.payload = {2'b0, b[2:0]};
        l.rem     = 3'd3;
      end
      [8'hF8:8'hFB]: begin
        l.payload = {3'b0, b[1:0]};
        l.rem     = 3'd4;
      end
      [8'hFC:8'hFD]: begin
        l.payload = {4'b0, b[0]};
        l.rem     = 3'd5;
      end
      default: begin
        l.single = 1'b1;
      end
    endcase
    return l;
  endfunction

endpackage

/* sv/utfd_if.sv */
// ----------------------------------------------------------------------------
// utfd_if: UTF-8 decoder channel interfaces
// Byte request channel and code point result channel, valid/ready.
// ----------------------------------------------------------------------------
interface utfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utfd_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic        complete;
  logic        last_in_run;

  modport source (output valid, output code_point, output complete, output last_in_run,
                  input ready);
  modport sink   (input valid, input code_point, input complete, input last_in_run,
                  output ready);
endinterface

/* sv/utfd_decode.sv */
// ----------------------------------------------------------------------------
// utfd_decode: per-byte decode step
// Computes up to two results and the next accumulator state for one byte.
// ----------------------------------------------------------------------------
module utfd_decode import utfd_pkg::*; (
  input  logic [ByteW-1:0] byte_i,
  input  logic             eot_i,
  input  logic [CpW-1:0]   acc_i,
  input  logic [RemW-1:0]  rem_i,
  output logic [1:0]       n_o,
  output result_t          r0_o,
  output result_t          r1_o,
  output logic [CpW-1:0]   acc_o,
  output logic [RemW-1:0]  rem_o
);

  lead_t          lead;
  logic           is_cont;
  logic [CpW-1:0] acc_sh;
  logic [RemW-1:0] rem_m;
  result_t        lead_res;

  assign lead    = classify_lead(byte_i);
  assign is_cont = (byte_i[7:6] == ContTag);
  assign acc_sh  = {acc_i[CpW-7:0], byte_i[5:0]};
  assign rem_m   = rem_i - 3'd1;

  // Result of a byte handled as a fresh lead (single value or cut-off lead)
  always_comb begin
    if (lead.single) begin
      lead_res = '{code_point: {{(CpW-ByteW){1'b0}}, byte_i}, complete: 1'b1,
                   last_in_run: 1'b1};
    end else begin
      lead_res = '{code_point: {{(CpW-LeadW){1'b0}}, lead.payload}, complete: 1'b0,
                   last_in_run: 1'b1};
    end
  end

  always_comb begin
    n_o   = NoResult;
    r0_o  = lead_res;
    r1_o  = lead_res;
    acc_o = '0;
    rem_o = '0;
    if (rem_i == '0) begin
      if (lead.single || eot_i) begin
        n_o = OneResult;
      end else begin
        acc_o = {{(CpW-LeadW){1'b0}}, lead.payload};
        rem_o = lead.rem;
      end
    end else if (is_cont) begin
      r0_o = '{code_point: acc_sh, complete: (rem_m == '0), last_in_run: 1'b1};
      if (rem_m == '0 || eot_i) begin
        n_o = OneResult;
      end else begin
        acc_o = acc_sh;
        rem_o = rem_m;
      end
    end else begin
      // Broken sequence: flush partial value, then restart on this byte
      r0_o = '{code_point: acc_i, complete: 1'b0, last_in_run: 1'b0};
      if (lead.single || eot_i) begin
        n_o = TwoResult;
      end else begin
        n_o              = OneResult;
        r0_o.last_in_run = 1'b1;
        acc_o            = {{(CpW-LeadW){1'b0}}, lead.payload};
        rem_o            = lead.rem;
      end
    end
  end

endmodule

/* sv/utfd_outbuf.sv */
// ----------------------------------------------------------------------------
// utfd_outbuf: result register with one overflow slot
// Holds the visible result and a second result from the same byte.
// ----------------------------------------------------------------------------
module utfd_outbuf import utfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [1:0]  n_i,
  input  result_t     r0_i,
  input  result_t     r1_i,
  output logic        free_o,
  utfd_cp_if.source   out_o
);

  logic    out_valid_q, out_valid_d;
  logic    pend_valid_q, pend_valid_d;
  result_t out_q, out_d;
  result_t pend_q, pend_d;
  logic    pop;

  assign pop    = out_valid_q && out_o.ready;
  assign free_o = !pend_valid_q && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d  = out_valid_q && !pop;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    if (pend_valid_q) begin
      if (!out_valid_q || pop) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end
    end else if (push_i) begin
      case (n_i)
        NoResult: begin
          out_valid_d = out_valid_q && !pop;
        end
        OneResult: begin
          out_d       = r0_i;
          out_valid_d = 1'b1;
        end
        TwoResult: begin
          out_d        = r0_i;
          out_valid_d  = 1'b1;
          pend_d       = r1_i;
          pend_valid_d = 1'b1;
        end
        default: begin
          out_valid_d = out_valid_q && !pop;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code_point  = out_q.code_point;
  assign out_o.complete    = out_q.complete;
  assign out_o.last_in_run = out_q.last_in_run;

endmodule

/* sv/utf8_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: UTF-8 stream decoder, 1-to-6-byte form
// Decodes a byte per cycle unless stalled, to 31-bit code points; flags cuts.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                  | handshake
//   in_i    | in  | data_byte[7:0], end_of_text              | valid/ready
//   out_o   | out | code_point[30:0], complete, last_in_run   | valid/ready
//
// One byte request is taken per cycle while the input register can empty; a
// result is decoded from the input register into the result register. A
// byte that yields two results (a broken sequence flushed before a single
// byte or a cut-off lead) holds the next byte until the overflow slot drains.
// Reset clears the accumulator, the pending count and all valid flags. A stalled
// output backs up into the input register; new bytes enter as it empties.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top import utfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  utfd_byte_if.sink in_i,
  utfd_cp_if.source out_o
);

  // Input register: parts the request side from the decode step
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_eot_q;

  // Decoder state: partial code point and continuation bytes still expected
  logic [CpW-1:0]  acc_q, acc_d;
  logic [RemW-1:0] rem_q, rem_d;

  logic       consume;
  logic       free;
  logic       accept;
  logic [1:0] n;
  result_t    r0, r1;

  // Advance a byte out of the input register once its results fit downstream
  assign consume    = in_valid_q && free;
  assign in_i.ready = !in_valid_q || consume;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      acc_q      <= '0;
      rem_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      acc_q      <= acc_d;
      rem_q      <= rem_d;
    end
  end

  // Capture the payload only on acceptance; hold it otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_i.data_byte;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  logic [CpW-1:0]  dec_acc;
  logic [RemW-1:0] dec_rem;

  utfd_decode u_decode (
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .acc_i  (acc_q),
    .rem_i  (rem_q),
    .n_o    (n),
    .r0_o   (r0),
    .r1_o   (r1),
    .acc_o  (dec_acc),
    .rem_o  (dec_rem)
  );

  // Update the sequence state only when the byte is actually consumed
  assign acc_d = consume ? dec_acc : acc_q;
  assign rem_d = consume ? dec_rem : rem_q;

  utfd_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (consume),
    .n_i    (n),
    .r0_i   (r0),
    .r1_i   (r1),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: UTF-8 stream decoder testbench
// Drives byte requests with random gaps, predicts every code point from a
// shadow decoder and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench import utfd_pkg::*; ();

  // Cycles without any handshake before the run is declared hung
  localparam int unsigned StallLimit = 2000;
  // Cycles to wait after the last expected result for strays
  localparam int unsigned TailCycles = 8;
  // Random part of the stimulus, in bytes
  localparam int unsigned RandomBytes = 900;

  logic clk_i;
  logic rst_ni;

  utfd_byte_if byte_req ();
  utfd_cp_if   cp_rsp ();

  utf8_stream_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_req),
    .out_o  (cp_rsp)
  );

  // Shadow decoder state, advanced once per accepted byte request
  logic [CpW-1:0]  shadow_acc;
  logic [RemW-1:0] shadow_rem;

  // Code points predicted but not yet seen on the output, oldest first
  result_t pending_cps[$];

  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned stall_cycles;
  // Suppress random idling on both sides while set
  bit          quiet;

  // --------------------------------------------------------------------------
  // Clock and initial values of every driven input
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni               = 1'b0;
    byte_req.valid       = 1'b0;
    byte_req.data_byte   = '0;
    byte_req.end_of_text = 1'b0;
    cp_rsp.ready         = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow decoder
  // --------------------------------------------------------------------------
  function automatic void push_cp(input logic [CpW-1:0] cp, input logic whole,
                                  input logic last);
    result_t r;
    r.code_point  = cp;
    r.complete    = whole;
    r.last_in_run = last;
    pending_cps   = {pending_cps, r};
  endfunction

  // Handle a byte with no sequence open: emit it as a single value, or open
  // a new sequence (closed again at once when the text ends on the lead).
  function automatic void open_lead(input logic [7:0] b, input logic eot);
    logic [CpW-1:0]  payload;
    logic [RemW-1:0] count;
    payload = '0;
    count   = '0;
    if (b < 8'hC0 || b >= 8'hFE) begin
      push_cp({23'b0, b}, 1'b1, 1'b1);
      return;
    end
    if (b < 8'hE0) begin
      payload = CpW'(b & 8'h1F);
      count   = 3'd1;
    end else if (b < 8'hF0) begin
      payload = CpW'(b & 8'h0F);
      count   = 3'd2;
    end else if (b < 8'hF8) begin
      payload = CpW'(b & 8'h07);
      count   = 3'd3;
    end else if (b < 8'hFC) begin
      payload = CpW'(b & 8'h03);
      count   = 3'd4;
    end else begin
      payload = CpW'(b & 8'h01);
      count   = 3'd5;
    end
    if (eot) begin
      shadow_acc = '0;
      shadow_rem = '0;
      push_cp(payload, 1'b0, 1'b1);
    end else begin
      shadow_acc = payload;
      shadow_rem = count;
    end
  endfunction

  // Advance the shadow decoder by one accepted byte and queue its results
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic lead_emits;
    if (shadow_rem == '0) begin
      open_lead(b, eot);
      return;
    end
    if (b[7:6] == ContTag) begin
      // Shift six payload bits in; the top bits fall off the 31-bit value
      shadow_acc = {shadow_acc[CpW-7:0], b[5:0]};
      shadow_rem = shadow_rem - 3'd1;
      if (shadow_rem == '0) begin
        push_cp(shadow_acc, 1'b1, 1'b1);
        shadow_acc = '0;
      end else if (eot) begin
        push_cp(shadow_acc, 1'b0, 1'b1);
        shadow_acc = '0;
        shadow_rem = '0;
      end
      return;
    end
    // Broken sequence: flush the partial value, then restart on this byte.
    // The flush is the last result only when the new byte emits nothing.
    lead_emits = (b < 8'hC0) || (b >= 8'hFE) || eot;
    push_cp(shadow_acc, 1'b0, !lead_emits);
    shadow_acc = '0;
    shadow_rem = '0;
    open_lead(b, eot);
  endfunction

  // --------------------------------------------------------------------------
  // Byte request driver
  // --------------------------------------------------------------------------
  // Hold the request until accepted, then predict. Valid is left high on
  // return so that back-to-back requests never drop it within a time step.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!quiet && $urandom_range(99) < 8) begin
      byte_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_req.valid       <= 1'b1;
    byte_req.data_byte   <= b;
    byte_req.end_of_text <= eot;
    do @(posedge clk_i); while (!byte_req.ready);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  // Send a sequence of len bytes with random payload, cut after sent_len
  // bytes; the text ends on the last byte sent when eot_last is set.
  task automatic send_sequence(input int unsigned len, input int unsigned sent_len,
                               input logic eot_last);
    logic [7:0] b;
    for (int unsigned k = 0; k < sent_len; k++) begin
      if (k != 0) begin
        b = 8'h80 | 8'($urandom_range(63));
      end else begin
        case (len)
          1:       b = 8'($urandom_range(127));
          2:       b = 8'hC0 | 8'($urandom_range(31));
          3:       b = 8'hE0 | 8'($urandom_range(15));
          4:       b = 8'hF0 | 8'($urandom_range(7));
          5:       b = 8'hF8 | 8'($urandom_range(3));
          default: b = 8'hFC | 8'($urandom_range(1));
        endcase
      end
      send_byte(b, eot_last && (k == sent_len - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random backpressure and in-order check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (cp_rsp.valid && cp_rsp.ready) begin
      if (pending_cps.size() == 0) begin
        $error("unexpected result: code_point %h complete %b last_in_run %b",
               cp_rsp.code_point, cp_rsp.complete, cp_rsp.last_in_run);
        mismatches++;
      end else begin
        want = pending_cps.pop_front();
        if (cp_rsp.code_point !== want.code_point) begin
          $error("code_point: expected %h, actual %h", want.code_point, cp_rsp.code_point);
          mismatches++;
        end
        if (cp_rsp.complete !== want.complete) begin
          $error("complete: expected %b, actual %b", want.complete, cp_rsp.complete);
          mismatches++;
        end
        if (cp_rsp.last_in_run !== want.last_in_run) begin
          $error("last_in_run: expected %b, actual %b", want.last_in_run,
                 cp_rsp.last_in_run);
          mismatches++;
        end
      end
    end
    // Drop ready about 8 percent of the time unless quiet
    cp_rsp.ready <= quiet || ($urandom_range(99) >= 8);
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no handshake happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_req.valid && byte_req.ready) || (cp_rsp.valid && cp_rsp.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Single bytes: ASCII extremes, stray continuations and the two bytes that
  // can never start a sequence, with and without the end of text.
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Whole sequences of 2 to 6 bytes: largest payloads, smallest at 2 and 6 bytes
  task automatic test_full_sequences();
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0);
    repeat (3) send_byte(8'hBF, 1'b0);
    send_byte(8'hFB, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    // Largest value the 31-bit code point can hold
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    send_byte(8'hFC, 1'b0);
    repeat (5) send_byte(8'h80, 1'b0);
  endtask

  // Broken sequences: interrupted by a single byte, by a new lead, and by a
  // lead that is itself the last byte of the text (two results from one byte)
  task automatic test_broken_sequences();
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hE0, 1'b1);
    send_byte(8'hFC, 1'b0); send_byte(8'h7F, 1'b1);
  endtask

  // End of text on a lead, inside a sequence, and on its final byte
  task automatic test_end_of_text();
    send_byte(8'hFD, 1'b1);
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b1);
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b1);
  endtask

  // Random text: mostly well-formed sequences with random payload, plus cut
  // sequences and raw noise; a long stretch runs without any idling.
  task automatic test_random_text();
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      quiet = (bytes_sent - start >= 350) && (bytes_sent - start < 500);
      pick  = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(6, 1);
        send_sequence(len, len, $urandom_range(99) < 10);
      end else if (pick < 85) begin
        len = $urandom_range(6, 2);
        send_sequence(len, $urandom_range(len - 1, 1), $urandom_range(99) < 30);
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
      end
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    shadow_acc   = '0;
    shadow_rem   = '0;
    bytes_sent   = 0;
    mismatches   = 0;
    stall_cycles = 0;
    quiet        = 1'b0;

    // Hold reset, then release it on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_full_sequences();
    test_broken_sequences();
    test_end_of_text();
    test_random_text();

    // Stop requesting, drain every expected result, then watch for strays
    byte_req.valid <= 1'b0;
    while (pending_cps.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_cps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/utfd_pkg.sv
sv/utfd_if.sv
sv/utfd_decode.sv
sv/utfd_outbuf.sv
sv/utf8_stream_decoder_top.sv
tb/testbench.sv
